// ===== hdl/osm_pkg.sv =====
// ---------------------------------------------------------------------------
// osm_pkg: shared types and codes for the order statistic multiset
// Operation and status codes, the item structs of both channels and the
// result struct of the shared compare unit.
// ---------------------------------------------------------------------------
package osm_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_SELECT = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] operand;
  } in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== hdl/osm_cmp.sv =====
// ---------------------------------------------------------------------------
// osm_cmp: shared signed comparator
// Compares a stored value against the search key; used by every search
// step and by the match check of a delete.
// ---------------------------------------------------------------------------
module osm_cmp #(
  parameter int VALUE_BITS = 32
) (
  input  logic signed [VALUE_BITS-1:0] a,
  input  logic signed [VALUE_BITS-1:0] b,
  output osm_pkg::cmp_res_t            res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

// ===== hdl/osm_store.sv =====
// ---------------------------------------------------------------------------
// osm_store: sorted value memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module osm_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [WIDTH-1:0] rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/order_statistic_multiset_core.sv =====
// ---------------------------------------------------------------------------
// order_statistic_multiset_core: bounded sorted multiset with rank/select
// Keeps values in ascending order in one memory. A binary search drives a
// single comparator; insert and delete then move entries one at a time.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+---------------------------------
//   input    | in_item               | transfer when start && !busy
//   result   | out_item              | out_valid strobe, one cycle
//
// While busy, a search halving passes S_SRCH, S_SCMP; a last S_SRCH ends it.
// Delete, predecessor, successor fetch via S_FETCH, S_FWAIT; select fetches
// with no search; insert writes the key in S_PUTKEY; insert and delete move
// each entry via S_MVRD, S_MVWR. Full store, unknown codes and out-of-range
// select never raise busy. The strobe follows the last busy cycle with busy
// low; the receiver cannot stall. Reset empties the store; no clearing pass.
// ---------------------------------------------------------------------------
module order_statistic_multiset_core #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  osm_pkg::in_t   in_item,
  output logic           out_valid,
  output osm_pkg::out_t  out_item
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int EXT = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCH   = 3'd1;
  localparam logic [2:0] S_SCMP   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_FWAIT  = 3'd4;
  localparam logic [2:0] S_MVRD   = 3'd5;
  localparam logic [2:0] S_MVWR   = 3'd6;
  localparam logic [2:0] S_PUTKEY = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [2:0]                  op_r, op_nxt;
  logic signed [VALUE_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               lo_r, lo_nxt;
  logic [CW-1:0]               hi_r, hi_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               faddr_r, faddr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  osm_pkg::out_t               out_item_r, out_item_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic signed [VALUE_BITS-1:0] rd_data;
  logic signed [EXT-1:0]       rd_ext;
  logic signed [EXT-1:0]       opnd_ext;
  logic [31:0]                 k_sel;
  logic [CW:0]                 mid_sum;
  logic                        upto_mode;
  logic                        go_left;
  osm_pkg::cmp_res_t           cmp_res;

  osm_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  osm_cmp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .a   (rd_data),
    .b   (key_r),
    .res (cmp_res)
  );

  assign rd_ext    = EXT'(rd_data);
  assign opnd_ext  = EXT'(in_item.operand);
  assign k_sel     = in_item.operand;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  // insert and successor look for the first entry above the key
  assign upto_mode = (op_r == osm_pkg::OP_INSERT) || (op_r == osm_pkg::OP_SUCC);
  assign go_left   = cmp_res.lt || (upto_mode && cmp_res.eq);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    faddr_nxt     = faddr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = rd_data;
    mem_raddr     = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_item.operation;
          key_nxt = opnd_ext[VALUE_BITS-1:0];
          lo_nxt  = '0;
          hi_nxt  = count_r;
          out_item_nxt.answer = '0;
          case (in_item.operation)
            osm_pkg::OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_item_nxt.status = osm_pkg::ST_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            osm_pkg::OP_DELETE, osm_pkg::OP_RANK, osm_pkg::OP_PRED,
            osm_pkg::OP_SUCC: begin
              state_nxt = S_SRCH;
            end
            osm_pkg::OP_SELECT: begin
              if (k_sel == 32'd0 || k_sel > 32'(count_r)) begin
                out_item_nxt.status = osm_pkg::ST_NOTFOUND;
                out_valid_nxt       = 1'b1;
              end else begin
                faddr_nxt = AW'(k_sel - 32'd1);
                state_nxt = S_FETCH;
              end
            end
            default: begin
              out_item_nxt.status = osm_pkg::ST_NOTFOUND;
              out_valid_nxt       = 1'b1;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[AW:1];
          mem_raddr = mid_sum[AW:1];
          state_nxt = S_SCMP;
        end else begin
          case (op_r)
            osm_pkg::OP_INSERT: begin
              if (lo_r == count_r) begin
                state_nxt = S_PUTKEY;
              end else begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_MVRD;
              end
            end
            osm_pkg::OP_DELETE: begin
              if (lo_r == count_r) begin
                out_item_nxt.status = osm_pkg::ST_NOTFOUND;
                out_valid_nxt       = 1'b1;
                state_nxt           = S_IDLE;
              end else begin
                faddr_nxt = AW'(lo_r);
                state_nxt = S_FETCH;
              end
            end
            osm_pkg::OP_RANK: begin
              out_item_nxt.answer = 32'(lo_r) + 32'd1;
              out_item_nxt.status = osm_pkg::ST_OK;
              out_valid_nxt       = 1'b1;
              state_nxt           = S_IDLE;
            end
            osm_pkg::OP_PRED: begin
              if (lo_r == '0) begin
                out_item_nxt.status = osm_pkg::ST_NOTFOUND;
                out_valid_nxt       = 1'b1;
                state_nxt           = S_IDLE;
              end else begin
                faddr_nxt = AW'(lo_r - CW'(1));
                state_nxt = S_FETCH;
              end
            end
            default: begin
              // successor
              if (lo_r == count_r) begin
                out_item_nxt.status = osm_pkg::ST_NOTFOUND;
                out_valid_nxt       = 1'b1;
                state_nxt           = S_IDLE;
              end else begin
                faddr_nxt = AW'(lo_r);
                state_nxt = S_FETCH;
              end
            end
          endcase
        end
      end

      S_SCMP: begin
        if (go_left) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
        state_nxt = S_SRCH;
      end

      S_FETCH: begin
        mem_raddr = faddr_r;
        state_nxt = S_FWAIT;
      end

      S_FWAIT: begin
        if (op_r == osm_pkg::OP_DELETE) begin
          if (!cmp_res.eq) begin
            out_item_nxt.status = osm_pkg::ST_NOTFOUND;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else if (CW'(faddr_r) + CW'(1) == count_r) begin
            count_nxt           = count_r - CW'(1);
            out_item_nxt.status = osm_pkg::ST_OK;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            idx_nxt   = faddr_r + AW'(1);
            state_nxt = S_MVRD;
          end
        end else begin
          out_item_nxt.answer = rd_ext[31:0];
          out_item_nxt.status = osm_pkg::ST_OK;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      S_MVRD: begin
        mem_raddr = idx_r;
        state_nxt = S_MVWR;
      end

      S_MVWR: begin
        mem_we = 1'b1;
        if (op_r == osm_pkg::OP_INSERT) begin
          // open a gap: move entry up by one
          mem_waddr = idx_r + AW'(1);
          if (CW'(idx_r) == lo_r) begin
            state_nxt = S_PUTKEY;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_MVRD;
          end
        end else begin
          // close the gap: move entry down by one
          mem_waddr = idx_r - AW'(1);
          if (CW'(idx_r) + CW'(1) == count_r) begin
            count_nxt           = count_r - CW'(1);
            out_item_nxt.status = osm_pkg::ST_OK;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_MVRD;
          end
        end
      end

      S_PUTKEY: begin
        mem_we              = 1'b1;
        mem_waddr           = AW'(lo_r);
        mem_wdata           = key_r;
        count_nxt           = count_r + CW'(1);
        out_item_nxt.status = osm_pkg::ST_OK;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    faddr_r    <= faddr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/osm_chk.sv =====
// ---------------------------------------------------------------------------
// osm_chk: port-level checks for the order statistic multiset
// Watches the command and result ports; bound to the top level.
// ---------------------------------------------------------------------------
module osm_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input osm_pkg::in_t  in_item,
  input logic          out_valid,
  input osm_pkg::out_t out_item
);

  // results only appear once the block is free again
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a failed operation carries a zero answer
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != osm_pkg::ST_OK) |-> out_item.answer == 32'sd0)
    else $error("non-zero answer with error status");

  // an unknown operation is refused in the next cycle
  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation > osm_pkg::OP_SUCC) |=>
      (out_valid && out_item.status == osm_pkg::ST_NOTFOUND))
    else $error("unknown operation not refused");

  // a long operation ends with exactly its result
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("operation ended without result");

endmodule

bind order_statistic_multiset_core osm_chk u_osm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== bench/tb_order_statistic_multiset_core.sv =====
// ---------------------------------------------------------------------------
// tb_order_statistic_multiset_core: self-checking bench for the multiset core
// Drives insert, delete, rank, select, predecessor and successor commands
// through the start/busy handshake. A sorted queue mirrors the store and
// predicts answer and status for every accepted transfer. Each result strobe
// is checked against the oldest prediction. Covers empty and full store,
// the value extremes, duplicates and undefined operation codes. Random
// traffic runs with no idling, heavy idling and light idling.
// ---------------------------------------------------------------------------
module tb_order_statistic_multiset_core;

  localparam int CLK_PERIOD     = 8;
  localparam int HALF_PERIOD    = CLK_PERIOD / 2;
  localparam int CAPACITY       = 1024;
  localparam int RESET_CYCLES   = 10;
  localparam int TAIL_CYCLES    = 32;
  localparam longint TIMEOUT_CYCLES = 2_000_000;
  localparam int SOFT_SIZE_LIMIT = 64;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           start     = 1'b0;
  osm_pkg::in_t   in_item   = '0;
  logic           busy;
  logic           out_valid;
  osm_pkg::out_t  out_item;

  // mirror of the store, ascending, duplicates after their equals
  logic signed [31:0] multiset[$];
  osm_pkg::out_t      pending_answers[$];
  int                 idle_pct   = 0;
  int                 fail_count = 0;

  order_statistic_multiset_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int count_below(input logic signed [31:0] v);
    int n;
    n = 0;
    while (n < multiset.size() && multiset[n] < v) n++;
    return n;
  endfunction

  function automatic int count_upto(input logic signed [31:0] v);
    int n;
    n = 0;
    while (n < multiset.size() && multiset[n] <= v) n++;
    return n;
  endfunction

  // apply one command to the mirror and return the answer it must give
  function automatic osm_pkg::out_t apply_to_multiset(input osm_pkg::in_t cmd);
    osm_pkg::out_t res;
    int   pos;
    logic signed [31:0] v;
    res = '{answer: '0, status: osm_pkg::ST_OK};
    v   = cmd.operand;
    case (cmd.operation)
      osm_pkg::OP_INSERT: begin
        if (multiset.size() >= CAPACITY) begin
          res.status = osm_pkg::ST_FULL;
        end else begin
          multiset.insert(count_upto(v), v);
        end
      end
      osm_pkg::OP_DELETE: begin
        pos = count_below(v);
        if (pos >= multiset.size() || multiset[pos] != v) res.status = osm_pkg::ST_NOTFOUND;
        else multiset.delete(pos);
      end
      osm_pkg::OP_RANK: begin
        res.answer = count_below(v) + 1;
      end
      osm_pkg::OP_SELECT: begin
        // negative k counts as below one
        if (v < 1 || v > multiset.size()) res.status = osm_pkg::ST_NOTFOUND;
        else res.answer = multiset[v - 1];
      end
      osm_pkg::OP_PRED: begin
        pos = count_below(v);
        if (pos == 0) res.status = osm_pkg::ST_NOTFOUND;
        else res.answer = multiset[pos - 1];
      end
      osm_pkg::OP_SUCC: begin
        pos = count_upto(v);
        if (pos >= multiset.size()) res.status = osm_pkg::ST_NOTFOUND;
        else res.answer = multiset[pos];
      end
      default: begin
        res.status = osm_pkg::ST_NOTFOUND;
      end
    endcase
    return res;
  endfunction

  // start stays high across back-to-back transfers; lower it only to idle
  task automatic send_item(input logic [2:0] op, input logic signed [31:0] operand);
    osm_pkg::in_t cmd;
    cmd.operation = op;
    cmd.operand   = operand;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    pending_answers.push_back(apply_to_multiset(cmd));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    logic signed [31:0] extremes[6];
    extremes = '{VAL_MIN, VAL_MIN + 1, VAL_MAX, VAL_MAX - 1, 0, -1};
    r = $urandom_range(99);
    if (r < 35 && multiset.size() > 0) return multiset[$urandom_range(multiset.size() - 1)];
    if (r < 65) return $signed($urandom_range(16)) - 8;
    if (r < 75) return extremes[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    // empty store
    send_item(osm_pkg::OP_PRED, 0);
    send_item(osm_pkg::OP_SUCC, 0);
    send_item(osm_pkg::OP_RANK, 5);
    send_item(osm_pkg::OP_SELECT, 1);
    send_item(osm_pkg::OP_DELETE, 7);
    // extremes and duplicates
    send_item(osm_pkg::OP_INSERT, VAL_MIN);
    send_item(osm_pkg::OP_INSERT, VAL_MAX);
    send_item(osm_pkg::OP_INSERT, 0);
    send_item(osm_pkg::OP_INSERT, 0);
    send_item(osm_pkg::OP_INSERT, -1);
    send_item(osm_pkg::OP_RANK, 0);
    send_item(osm_pkg::OP_RANK, VAL_MAX);
    send_item(osm_pkg::OP_RANK, VAL_MIN);
    // select out of range on both sides, negative k included
    send_item(osm_pkg::OP_SELECT, 0);
    send_item(osm_pkg::OP_SELECT, -1);
    send_item(osm_pkg::OP_SELECT, VAL_MAX);
    send_item(osm_pkg::OP_SELECT, 6);
    // nothing below the minimum, nothing above the maximum
    send_item(osm_pkg::OP_PRED, VAL_MIN);
    send_item(osm_pkg::OP_SUCC, VAL_MAX);
    send_item(osm_pkg::OP_SUCC, 0);
    send_item(osm_pkg::OP_PRED, 0);
    send_item(osm_pkg::OP_DELETE, 0);
    send_item(osm_pkg::OP_DELETE, 1);
    send_item(OP_UNUSED_A, $urandom);
    send_item(OP_UNUSED_B, $urandom);
    wait_drained();
  endtask

  task automatic test_full_store();
    longint fill_value;
    logic signed [31:0] mid;
    idle_pct = 19;
    // empty from the top so that no entry has to move unless the top value is duplicated
    while (multiset.size() > 0) begin
      send_item(osm_pkg::OP_DELETE, multiset[multiset.size() - 1]);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      fill_value = longint'(VAL_MIN) + longint'(i) * 64'sd4194304
                 + longint'($urandom_range(4194303));
      send_item(osm_pkg::OP_INSERT, fill_value[31:0]);
    end
    send_item(osm_pkg::OP_INSERT, VAL_MAX);
    send_item(osm_pkg::OP_INSERT, VAL_MIN);
    send_item(osm_pkg::OP_INSERT, $urandom);
    send_item(osm_pkg::OP_SELECT, CAPACITY);
    send_item(osm_pkg::OP_SELECT, CAPACITY + 1);
    send_item(osm_pkg::OP_RANK, VAL_MAX);
    send_item(osm_pkg::OP_PRED, VAL_MAX);
    send_item(osm_pkg::OP_SUCC, VAL_MIN);
    mid = multiset[CAPACITY / 2];
    send_item(osm_pkg::OP_DELETE, mid);
    send_item(osm_pkg::OP_INSERT, mid);
    send_item(osm_pkg::OP_INSERT, mid);
    wait_drained();
  endtask

  task automatic test_random_phase(input int pct, input int n_items);
    int r;
    int n;
    logic [2:0] op;
    logic signed [31:0] val;
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(99);
      n   = multiset.size();
      val = pick_value();
      if (r < 30)      op = (n >= SOFT_SIZE_LIMIT) ? osm_pkg::OP_DELETE : osm_pkg::OP_INSERT;
      else if (r < 50) op = osm_pkg::OP_DELETE;
      else if (r < 62) op = osm_pkg::OP_RANK;
      else if (r < 74) op = osm_pkg::OP_SELECT;
      else if (r < 86) op = osm_pkg::OP_PRED;
      else if (r < 98) op = osm_pkg::OP_SUCC;
      else             op = $urandom_range(1) ? OP_UNUSED_B : OP_UNUSED_A;
      if (op == osm_pkg::OP_DELETE && n > 0 && $urandom_range(3) != 0) begin
        val = multiset[$urandom_range(n - 1)];
      end
      if (op == osm_pkg::OP_SELECT) begin
        r = $urandom_range(99);
        if (r < 75 && n > 0) val = $urandom_range(n, 1);
        else if (r < 85)     val = $urandom_range(1) ? n + 1 : 0;
        else                 val = $urandom;
      end
      send_item(op, val);
    end
    // hold off until every outstanding result is back
    wait_drained();
  endtask

  always @(posedge clk) begin : result_check
    osm_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: answer %0d status %0d", out_item.answer, out_item.status);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_item.answer !== want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, out_item.answer);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 40);
    test_random_phase(50, 40);
    test_random_phase(19, 20);
    test_full_store();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
